[hdl/isort_pkg.sv]
package isort_pkg;

   typedef struct packed {
      logic signed [31:0] value;
      logic               end_of_list;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_out;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic shift_down;
   } cell_ctrl_type;

endpackage

[hdl/isort_cell.sv]
module isort_cell (
   input  logic                     clock,
   input  isort_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]       new_value,
   input  logic                     occupied,
   input  logic signed [31:0]       left_value,
   input  logic                     left_slot,
   input  logic signed [31:0]       right_value,
   output logic signed [31:0]       value_out,
   output logic                     slot_out
);
   import isort_pkg::*;

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               slot;

   // A cell is at or above the insertion point when it is empty or holds a
   // strictly greater value; equal values stay below, which keeps the sort stable.
   assign slot = !occupied || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && slot) begin
         value_in = left_slot ? left_value : new_value;
      end else if (ctrl.shift_down) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign slot_out  = slot;

endmodule

[hdl/insertion_sorter.sv]
// Insertion: one element accepted per cycle while busy is low; every cell
// compares and shifts in the same cycle.
// End of list: the first result follows in the cycle after the marking beat is
// accepted, then one result per cycle for all N held values; busy is high while
// they are output. Results cannot be stalled by the receiver.
// Reset clears the fill count, drain state and drop flag; cell contents are not cleared.
module insertion_sorter #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  isort_pkg::req_type req_data,
   output logic               rsp_strobe,
   output isort_pkg::rsp_type rsp_data
);
   import isort_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               drain_ff, drain_in;
   logic               dropped_ff, dropped_in;
   logic               accept;
   cell_ctrl_type      ctrl;
   logic signed [31:0] value_w [DEPTH];
   logic               slot_w  [DEPTH];

   assign accept          = start && !busy;
   assign ctrl.insert     = accept && (count_ff < CW'(DEPTH));
   assign ctrl.shift_down = drain_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] left_value;
      logic               left_slot;
      logic signed [31:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = req_data.value;
         assign left_slot  = 1'b0;
      end else begin : g_inner
         assign left_value = value_w[g-1];
         assign left_slot  = slot_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_value = value_w[g];
      end else begin : g_body
         assign right_value = value_w[g+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (req_data.value),
         .occupied    (CW'(g) < count_ff),
         .left_value  (left_value),
         .left_slot   (left_slot),
         .right_value (right_value),
         .value_out   (value_w[g]),
         .slot_out    (slot_w[g])
      );
   end

   always_comb begin
      count_in   = count_ff;
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (drain_ff) begin
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            drain_in   = 1'b0;
            dropped_in = 1'b0;
         end
      end else if (accept) begin
         if (ctrl.insert) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
         drain_in = req_data.end_of_list;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   assign busy                  = drain_ff;
   assign rsp_strobe            = drain_ff;
   assign rsp_data.sorted_value = value_w[0];
   assign rsp_data.last_out     = (count_ff == CW'(1));
   assign rsp_data.overflow     = dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count exceeds depth");

   a_eol_starts_drain: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_list |=> rsp_strobe)
      else $error("end of list did not start the result stream");

   a_stream_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=> rsp_strobe)
      else $error("result stream ended before the last beat");

   a_stream_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_out |=> !busy)
      else $error("block still busy after the last beat");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_out |=>
         rsp_data.sorted_value >= $past(rsp_data.sorted_value))
      else $error("results not in ascending order");

endmodule
